/* sv/fpq_pkg.sv */
// Shared constants and payload types of the face plane quadric core.
package fpq_pkg;

  localparam int COORD_W     = 16;               // vertex coordinate width
  localparam int COORD_FRAC  = 8;                // coordinate fraction bits
  localparam int COEF_FRAC   = 24;               // coefficient fraction bits
  localparam int OUT_W       = 48;               // quadric term width
  localparam int EDGE_W      = COORD_W + 1;      // edge vector component
  localparam int CROSS_W     = 2 * EDGE_W;       // one cross partial product
  localparam int NRM_W       = CROSS_W + 1;      // signed cross product component
  localparam int MAG_W       = NRM_W - 1;        // its magnitude
  localparam int NORM_MSB    = 30;               // normalized msb position
  localparam int UMAG_W      = NORM_MSB + 1;     // normalized magnitude
  localparam int POS_W       = 6;                // msb position of a magnitude
  localparam int SHAMT_W     = 5;                // normalize shift amount
  localparam int SQ_W        = 64;               // sum of squares
  localparam int SQRT_STAGES = SQ_W / 2;         // one root bit per stage
  localparam int LEN_W       = SQRT_STAGES + 1;  // rounded length
  localparam int QUO_W       = 26;               // unit component magnitude
  localparam int NUM_W       = LEN_W + QUO_W - 1; // dividend width
  localparam int DIV_STAGES  = QUO_W;            // one quotient bit per stage
  localparam int LANES       = 3;                // x, y, z

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] q_aa;
    logic signed [OUT_W-1:0] q_ab;
    logic signed [OUT_W-1:0] q_ac;
    logic signed [OUT_W-1:0] q_ad;
    logic signed [OUT_W-1:0] q_bb;
    logic signed [OUT_W-1:0] q_bc;
    logic signed [OUT_W-1:0] q_bd;
    logic signed [OUT_W-1:0] q_cc;
    logic signed [OUT_W-1:0] q_cd;
    logic signed [OUT_W-1:0] q_dd;
    logic                    degenerate;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  // Travels alongside the square root.
  typedef struct packed {
    logic [UMAG_W-1:0] mx;
    logic [UMAG_W-1:0] my;
    logic [UMAG_W-1:0] mz;
    logic [LANES-1:0]  neg;
    vtx_t              a;
    logic              degen;
  } sq_side_t;

  // Travels alongside the divider.
  typedef struct packed {
    logic [LANES-1:0] neg;
    vtx_t             a;
    logic             degen;
  } dv_side_t;

endpackage

/* sv/fpq_sqrt.sv */
// Pipelined square root with round to nearest, one root bit per stage.
module fpq_sqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [fpq_pkg::SQ_W-1:0] rad_i,
  input  fpq_pkg::sq_side_t      side_i,
  output logic                   valid_o,
  output logic [fpq_pkg::LEN_W-1:0] len_o,
  output fpq_pkg::sq_side_t      side_o
);
  import fpq_pkg::*;

  localparam int LAST = SQRT_STAGES - 1;

  logic [SQRT_STAGES-1:0] vld_q;
  logic [SQ_W-1:0]        rem_q  [SQRT_STAGES];
  logic [SQ_W-1:0]        root_q [SQRT_STAGES];
  sq_side_t               side_q [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stg
    localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
    logic [SQ_W-1:0] rem_in, root_in, trial, rem_d, root_d;
    logic            vld_in;
    sq_side_t        side_in;

    if (i == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign vld_in  = vld_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = root_in + STEP_BIT;

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + STEP_BIT;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= rem_d;
      root_q[i] <= root_d;
      side_q[i] <= side_in;
    end
  end

  // Round: bump the root when the remainder exceeds it.
  logic [LEN_W-1:0] len_d, len_q;
  logic             vld_out_q;
  sq_side_t         side_out_q;

  assign len_d = LEN_W'(root_q[LAST]) + LEN_W'(rem_q[LAST] > root_q[LAST]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    side_out_q <= side_q[LAST];
  end

  assign valid_o = vld_out_q;
  assign len_o   = len_q;
  assign side_o  = side_out_q;

endmodule

/* sv/fpq_div.sv */
// Pipelined restoring divider, three lanes sharing one divisor.
module fpq_div (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic [fpq_pkg::LANES-1:0][fpq_pkg::NUM_W-1:0] num_i,
  input  logic [fpq_pkg::LEN_W-1:0]                  den_i,
  input  fpq_pkg::dv_side_t                          side_i,
  output logic                                       valid_o,
  output logic [fpq_pkg::LANES-1:0][fpq_pkg::QUO_W-1:0] quo_o,
  output fpq_pkg::dv_side_t                          side_o
);
  import fpq_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0]              vld_q;
  logic [LANES-1:0][NUM_W-1:0]        rem_q  [DIV_STAGES];
  logic [LANES-1:0][QUO_W-1:0]        quo_q  [DIV_STAGES];
  logic [LEN_W-1:0]                   den_q  [DIV_STAGES];
  dv_side_t                           side_q [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stg
    localparam int SHIFT = QUO_W - 1 - i;
    logic [LANES-1:0][NUM_W-1:0] rem_in, rem_d;
    logic [LANES-1:0][QUO_W-1:0] quo_in, quo_d;
    logic [LEN_W-1:0]            den_in;
    logic [NUM_W-1:0]            dsh;
    logic                        vld_in;
    dv_side_t                    side_in;

    if (i == 0) begin : g_first
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign den_in  = den_q[i-1];
      assign vld_in  = vld_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign dsh = NUM_W'(den_in) << SHIFT;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_d[l] = rem_in[l] - dsh;
          quo_d[l] = {quo_in[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = {quo_in[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= rem_d;
      quo_q[i]  <= quo_d;
      den_q[i]  <= den_in;
      side_q[i] <= side_in;
    end
  end

  assign valid_o = vld_q[LAST];
  assign quo_o   = quo_q[LAST];
  assign side_o  = side_q[LAST];

endmodule

/* sv/face_plane_quadric_core.sv */
// Top level of the face plane quadric core: plane of a triangle to quadric terms.
//
// Usage:
// - Input channel: drive one triangle (three Q8.8 vertices) on in_i and raise
//   start. A beat is taken at each rising edge with start high and busy low.
//   busy never rises: the pipeline takes a new triangle in every cycle.
// - Result channel: res_valid_o strobes for exactly one cycle with the ten
//   upper-triangle terms of the plane quadric (24 fraction bits) and the
//   degenerate flag on res_o. The receiver cannot stall; every result is
//   shown once and then replaced by later results.
// - Pipeline: 72 register stages from the accepting edge to res_o.
//   Throughput: one triangle per cycle, fixed.
// - Depth is set by the bit-serial square root (32 stages plus rounding) and
//   the shared-divisor divider (26 stages, one quotient bit each), with seven
//   stages of edge, cross product and normalize work ahead of the root, one
//   stage between the two units and five after the divider.
// - A zero cross product flows through like any other triangle and is forced
//   to all-zero terms with degenerate set at the last stage.
// - Reset clears every valid bit; payload registers are not reset, and no
//   strobe appears until a triangle has gone all the way through.
module face_plane_quadric_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  fpq_pkg::in_t   in_i,
  output logic           res_valid_o,
  output fpq_pkg::out_t  res_o
);
  import fpq_pkg::*;

  localparam int PR_W    = QUO_W + 1 + COORD_W;  // a * A.x
  localparam int SUM_W   = PR_W + 2;             // dot product
  localparam int DMAG_W  = 34;                   // |d| and term operand magnitude
  localparam int PROD_W  = 2 * DMAG_W;           // term product
  localparam int N_TERMS = 10;

  // Operand pairs of the terms: 0 a, 1 b, 2 c, 3 d.
  localparam logic [1:0] TERM_X [N_TERMS] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
                                              2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
  localparam logic [1:0] TERM_Y [N_TERMS] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                              2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  // Valid bits of the stages around the two units.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic v9_q, v10_q, v11_q, v12_q, v13_q;
  logic in_beat;

  assign busy    = 1'b0;
  assign in_beat = start & ~busy;

  // Stage 1: edge vectors E1 = B - A, E2 = C - A.
  logic signed [EDGE_W-1:0] e_d [6];
  logic signed [EDGE_W-1:0] e_q [6];
  vtx_t                     a1_d, a1_q;

  assign e_d[0] = EDGE_W'(in_i.b_x) - EDGE_W'(in_i.a_x);
  assign e_d[1] = EDGE_W'(in_i.b_y) - EDGE_W'(in_i.a_y);
  assign e_d[2] = EDGE_W'(in_i.b_z) - EDGE_W'(in_i.a_z);
  assign e_d[3] = EDGE_W'(in_i.c_x) - EDGE_W'(in_i.a_x);
  assign e_d[4] = EDGE_W'(in_i.c_y) - EDGE_W'(in_i.a_y);
  assign e_d[5] = EDGE_W'(in_i.c_z) - EDGE_W'(in_i.a_z);
  assign a1_d.x = in_i.a_x;
  assign a1_d.y = in_i.a_y;
  assign a1_d.z = in_i.a_z;

  // Stage 2: the six partial products of the cross product.
  logic signed [CROSS_W-1:0] p_d [6];
  logic signed [CROSS_W-1:0] p_q [6];
  vtx_t                      a2_q;

  assign p_d[0] = CROSS_W'(e_q[1]) * CROSS_W'(e_q[5]);
  assign p_d[1] = CROSS_W'(e_q[2]) * CROSS_W'(e_q[4]);
  assign p_d[2] = CROSS_W'(e_q[2]) * CROSS_W'(e_q[3]);
  assign p_d[3] = CROSS_W'(e_q[0]) * CROSS_W'(e_q[5]);
  assign p_d[4] = CROSS_W'(e_q[0]) * CROSS_W'(e_q[4]);
  assign p_d[5] = CROSS_W'(e_q[1]) * CROSS_W'(e_q[3]);

  // Stage 3: cross product, split into sign and magnitude.
  logic signed [NRM_W-1:0] n_d [LANES];
  logic signed [NRM_W-1:0] nabs_d [LANES];
  logic [MAG_W-1:0]        mag3_d [LANES];
  logic [MAG_W-1:0]        mag3_q [LANES];
  logic [LANES-1:0]        neg3_d, neg3_q;
  logic                    dg3_d, dg3_q;
  vtx_t                    a3_q;

  assign n_d[0] = NRM_W'(p_q[0]) - NRM_W'(p_q[1]);
  assign n_d[1] = NRM_W'(p_q[2]) - NRM_W'(p_q[3]);
  assign n_d[2] = NRM_W'(p_q[4]) - NRM_W'(p_q[5]);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      neg3_d[l] = n_d[l][NRM_W-1];
      nabs_d[l] = neg3_d[l] ? -n_d[l] : n_d[l];
      mag3_d[l] = nabs_d[l][MAG_W-1:0];
    end
  end

  assign dg3_d = (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);

  // Stage 4: find the msb of the largest magnitude and the normalize shift.
  logic [MAG_W-1:0]   mmax_d;
  logic [POS_W-1:0]   pos_d;
  logic               sr4_d, sr4_q;
  logic [SHAMT_W-1:0] amt4_d, amt4_q;
  logic [MAG_W-1:0]   mag4_q [LANES];
  logic [LANES-1:0]   neg4_q;
  logic               dg4_q;
  vtx_t               a4_q;

  always_comb begin
    mmax_d = mag3_q[0];
    if (mag3_q[1] > mmax_d) begin
      mmax_d = mag3_q[1];
    end
    if (mag3_q[2] > mmax_d) begin
      mmax_d = mag3_q[2];
    end
    pos_d = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mmax_d[b]) begin
        pos_d = POS_W'(b);
      end
    end
  end

  assign sr4_d  = (pos_d > POS_W'(NORM_MSB));
  assign amt4_d = sr4_d ? SHAMT_W'(pos_d - POS_W'(NORM_MSB))
                        : SHAMT_W'(POS_W'(NORM_MSB) - pos_d);

  // Stage 5: shift all three together, truncating on a right shift.
  logic [MAG_W+NORM_MSB-1:0] wide_d [LANES];
  logic [UMAG_W-1:0]         um5_d [LANES];
  logic [UMAG_W-1:0]         um5_q [LANES];
  logic [LANES-1:0]          neg5_q;
  logic                      dg5_q;
  vtx_t                      a5_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wide_d[l] = (MAG_W + NORM_MSB)'(mag4_q[l]) << amt4_q;
      um5_d[l]  = sr4_q ? UMAG_W'(mag4_q[l] >> amt4_q) : wide_d[l][UMAG_W-1:0];
    end
  end

  // Stage 6: squares.
  logic [2*UMAG_W-1:0] sq6_d [LANES];
  logic [2*UMAG_W-1:0] sq6_q [LANES];
  logic [UMAG_W-1:0]   um6_q [LANES];
  logic [LANES-1:0]    neg6_q;
  logic                dg6_q;
  vtx_t                a6_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sq6_d[l] = um5_q[l] * um5_q[l];
    end
  end

  // Stage 7: sum of squares, handed to the square root.
  logic [SQ_W-1:0] s7_d, s7_q;
  sq_side_t        side7_d, side7_q;

  assign s7_d = SQ_W'(sq6_q[0]) + SQ_W'(sq6_q[1]) + SQ_W'(sq6_q[2]);
  assign side7_d.mx    = um6_q[0];
  assign side7_d.my    = um6_q[1];
  assign side7_d.mz    = um6_q[2];
  assign side7_d.neg   = neg6_q;
  assign side7_d.a     = a6_q;
  assign side7_d.degen = dg6_q;

  logic             sq_vld;
  logic [LEN_W-1:0] sq_len;
  sq_side_t         sq_side;

  fpq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .rad_i   (s7_q),
    .side_i  (side7_q),
    .valid_o (sq_vld),
    .len_o   (sq_len),
    .side_o  (sq_side)
  );

  // Stage 8: dividends |N'| * 2^F + len/2.
  logic [UMAG_W-1:0]           um8_d [LANES];
  logic [LANES-1:0][NUM_W-1:0] num8_d, num8_q;
  logic [LEN_W-1:0]            len8_q;
  dv_side_t                    dside8_d, dside8_q;

  assign um8_d[0] = sq_side.mx;
  assign um8_d[1] = sq_side.my;
  assign um8_d[2] = sq_side.mz;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num8_d[l] = (NUM_W'(um8_d[l]) << COEF_FRAC) + NUM_W'(sq_len >> 1);
    end
  end

  assign dside8_d.neg   = sq_side.neg;
  assign dside8_d.a     = sq_side.a;
  assign dside8_d.degen = sq_side.degen;

  logic                        dv_vld;
  logic [LANES-1:0][QUO_W-1:0] dv_quo;
  dv_side_t                    dv_side;

  fpq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (num8_q),
    .den_i   (len8_q),
    .side_i  (dside8_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // Stage 9: signed unit components times the first vertex.
  logic signed [QUO_W:0]  su9_d [LANES];
  logic signed [PR_W-1:0] pr9_d [LANES];
  logic signed [PR_W-1:0] pr9_q [LANES];
  logic signed [COORD_W-1:0] av9_d [LANES];
  logic [QUO_W-1:0]       q9_q [LANES];
  logic [LANES-1:0]       neg9_q;
  logic                   dg9_q;

  assign av9_d[0] = dv_side.a.x;
  assign av9_d[1] = dv_side.a.y;
  assign av9_d[2] = dv_side.a.z;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      su9_d[l] = dv_side.neg[l] ? -$signed({1'b0, dv_quo[l]}) : $signed({1'b0, dv_quo[l]});
      pr9_d[l] = PR_W'(su9_d[l]) * PR_W'(av9_d[l]);
    end
  end

  // Stage 10: dot product.
  logic signed [SUM_W-1:0] sum10_d, sum10_q;
  logic [QUO_W-1:0]        q10_q [LANES];
  logic [LANES-1:0]        neg10_q;
  logic                    dg10_q;

  assign sum10_d = SUM_W'(pr9_q[0]) + SUM_W'(pr9_q[1]) + SUM_W'(pr9_q[2]);

  // Stage 11: round the offset to F fraction bits, half away from zero, negate.
  logic [SUM_W-1:0]  ms11_d, rd11_d;
  logic [DMAG_W-1:0] dm11_q;
  logic              dneg11_q;
  logic [QUO_W-1:0]  q11_q [LANES];
  logic [LANES-1:0]  neg11_q;
  logic              dg11_q;

  assign ms11_d = sum10_q[SUM_W-1] ? SUM_W'(-sum10_q) : SUM_W'(sum10_q);
  assign rd11_d = (ms11_d + (SUM_W'(1) << (COORD_FRAC - 1))) >> COORD_FRAC;

  // Stage 12: the ten term products on magnitudes.
  logic [DMAG_W-1:0]  opm12_d [4];
  logic [3:0]         opn12_d;
  logic [PROD_W-1:0]  prod12_d [N_TERMS];
  logic [PROD_W-1:0]  prod12_q [N_TERMS];
  logic [N_TERMS-1:0] tneg12_d, tneg12_q;
  logic               dg12_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      opm12_d[l] = DMAG_W'(q11_q[l]);
    end
    opm12_d[3] = dm11_q;
    opn12_d    = {dneg11_q, neg11_q};
    for (int t = 0; t < N_TERMS; t++) begin
      prod12_d[t] = PROD_W'(opm12_d[TERM_X[t]]) * PROD_W'(opm12_d[TERM_Y[t]]);
      tneg12_d[t] = opn12_d[TERM_X[t]] ^ opn12_d[TERM_Y[t]];
    end
  end

  // Stage 13: round, saturate, apply sign, drop degenerate triangles to zero.
  logic [PROD_W-1:0]       rr13_d [N_TERMS];
  logic [PROD_W-1:0]       lim13_d [N_TERMS];
  logic signed [OUT_W-1:0] term13_d [N_TERMS];
  out_t                    res_d, res_q;

  always_comb begin
    for (int t = 0; t < N_TERMS; t++) begin
      rr13_d[t]  = (prod12_q[t] + (PROD_W'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
      lim13_d[t] = tneg12_q[t] ? (PROD_W'(1) << (OUT_W - 1))
                               : (PROD_W'(1) << (OUT_W - 1)) - PROD_W'(1);
      if (rr13_d[t] > lim13_d[t]) begin
        rr13_d[t] = lim13_d[t];
      end
      if (dg12_q) begin
        term13_d[t] = '0;
      end else if (tneg12_q[t]) begin
        term13_d[t] = -$signed(rr13_d[t][OUT_W-1:0]);
      end else begin
        term13_d[t] = $signed(rr13_d[t][OUT_W-1:0]);
      end
    end
    res_d.q_aa       = term13_d[0];
    res_d.q_ab       = term13_d[1];
    res_d.q_ac       = term13_d[2];
    res_d.q_ad       = term13_d[3];
    res_d.q_bb       = term13_d[4];
    res_d.q_bc       = term13_d[5];
    res_d.q_bd       = term13_d[6];
    res_d.q_cc       = term13_d[7];
    res_d.q_cd       = term13_d[8];
    res_d.q_dd       = term13_d[9];
    res_d.degenerate = dg12_q;
  end

  // Valid bits advance every cycle; nothing holds them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
      v13_q <= 1'b0;
    end else begin
      v1_q  <= in_beat;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= sq_vld;
      v9_q  <= dv_vld;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
      v13_q <= v12_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    e_q      <= e_d;
    a1_q     <= a1_d;

    p_q      <= p_d;
    a2_q     <= a1_q;

    mag3_q   <= mag3_d;
    neg3_q   <= neg3_d;
    dg3_q    <= dg3_d;
    a3_q     <= a2_q;

    sr4_q    <= sr4_d;
    amt4_q   <= amt4_d;
    mag4_q   <= mag3_q;
    neg4_q   <= neg3_q;
    dg4_q    <= dg3_q;
    a4_q     <= a3_q;

    um5_q    <= um5_d;
    neg5_q   <= neg4_q;
    dg5_q    <= dg4_q;
    a5_q     <= a4_q;

    sq6_q    <= sq6_d;
    um6_q    <= um5_q;
    neg6_q   <= neg5_q;
    dg6_q    <= dg5_q;
    a6_q     <= a5_q;

    s7_q     <= s7_d;
    side7_q  <= side7_d;

    num8_q   <= num8_d;
    len8_q   <= sq_len;
    dside8_q <= dside8_d;

    pr9_q    <= pr9_d;
    for (int l = 0; l < LANES; l++) begin
      q9_q[l] <= dv_quo[l];
    end
    neg9_q   <= dv_side.neg;
    dg9_q    <= dv_side.degen;

    sum10_q  <= sum10_d;
    q10_q    <= q9_q;
    neg10_q  <= neg9_q;
    dg10_q   <= dg9_q;

    dm11_q   <= rd11_d[DMAG_W-1:0];
    dneg11_q <= ~sum10_q[SUM_W-1];
    q11_q    <= q10_q;
    neg11_q  <= neg10_q;
    dg11_q   <= dg10_q;

    prod12_q <= prod12_d;
    tneg12_q <= tneg12_d;
    dg12_q   <= dg11_q;

    res_q    <= res_d;
  end

  assign res_valid_o = v13_q;
  assign res_o       = res_q;

endmodule

/* sim/tb.sv */
// Self-checking testbench of the face plane quadric core against a bit-exact predictor.
module tb;
  import fpq_pkg::*;

  localparam int LATENCY   = 72;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 1200;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  in_t   in_i = '0;
  logic  res_valid_o;
  out_t  res_o;

  out_t  quad_pending[$];   // expected quadric beats, oldest first
  int    n_fail = 0;
  int    idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  face_plane_quadric_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  // Exact 128-bit product of two signed coefficients, rounded half away from zero
  // to COEF_FRAC fraction bits, saturated to the 48-bit term range.
  function automatic logic [OUT_W-1:0] round_term(longint x, longint y);
    logic [127:0] p;
    logic [127:0] r;
    logic         neg;
    logic [127:0] lim;
    neg = (x < 0) != (y < 0);
    p = 128'(x < 0 ? -x : x) * 128'(y < 0 ? -y : y);
    r = (p + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (r > lim) r = lim;
    return neg ? OUT_W'(-r) : OUT_W'(r);
  endfunction

  // Integer root of s, plus one when the remainder exceeds the root.
  function automatic longint unsigned nearest_root(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s > r) r++;
    return r;
  endfunction

  function automatic out_t plane_quadric(in_t t);
    longint ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
    longint unsigned mx, my, mz, m, len, rd, ms;
    longint a, b, c, d, sum;
    out_t q;
    ax = t.a_x; ay = t.a_y; az = t.a_z;
    e1x = longint'(t.b_x) - ax; e1y = longint'(t.b_y) - ay; e1z = longint'(t.b_z) - az;
    e2x = longint'(t.c_x) - ax; e2y = longint'(t.c_y) - ay; e2z = longint'(t.c_z) - az;
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    mx = nx < 0 ? -nx : nx;
    my = ny < 0 ? -ny : ny;
    mz = nz < 0 ? -nz : nz;
    m = mx;
    if (my > m) m = my;
    if (mz > m) m = mz;
    q = '0;
    if (m == 0) begin
      q.degenerate = 1'b1;
      return q;
    end
    while ((m >> 31) != 0) begin
      m >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
    end
    while ((m >> 30) == 0) begin
      m <<= 1; mx <<= 1; my <<= 1; mz <<= 1;
    end
    len = nearest_root(mx * mx + my * my + mz * mz);
    a = longint'(((mx << COEF_FRAC) + (len >> 1)) / len);
    b = longint'(((my << COEF_FRAC) + (len >> 1)) / len);
    c = longint'(((mz << COEF_FRAC) + (len >> 1)) / len);
    if (nx < 0) a = -a;
    if (ny < 0) b = -b;
    if (nz < 0) c = -c;
    sum = a * ax + b * ay + c * az;
    ms = sum < 0 ? -sum : sum;
    rd = (ms + (64'd1 << (COORD_FRAC - 1))) >> COORD_FRAC;
    d = sum < 0 ? longint'(rd) : -longint'(rd);
    q.q_aa = round_term(a, a); q.q_ab = round_term(a, b);
    q.q_ac = round_term(a, c); q.q_ad = round_term(a, d);
    q.q_bb = round_term(b, b); q.q_bc = round_term(b, c);
    q.q_bd = round_term(b, d); q.q_cc = round_term(c, c);
    q.q_cd = round_term(c, d); q.q_dd = round_term(d, d);
    return q;
  endfunction

  function automatic in_t tri_of(int v[9]);
    in_t t;
    t.a_x = COORD_W'(v[0]); t.a_y = COORD_W'(v[1]); t.a_z = COORD_W'(v[2]);
    t.b_x = COORD_W'(v[3]); t.b_y = COORD_W'(v[4]); t.b_z = COORD_W'(v[5]);
    t.c_x = COORD_W'(v[6]); t.c_y = COORD_W'(v[7]); t.c_z = COORD_W'(v[8]);
    return t;
  endfunction

  // Mostly small triangles near a random anchor; some full-range noise.
  function automatic in_t random_tri();
    int  base[3];
    int  spread;
    int  v[9];
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < 9; k++) v[k] = $urandom_range(0, 65535) - 32768;
      return tri_of(v);
    end
    spread = 1 << $urandom_range(0, 15);
    for (int k = 0; k < 3; k++) base[k] = $urandom_range(0, 65535) - 32768;
    for (int k = 0; k < 9; k++)
      v[k] = base[k % 3] + int'($urandom_range(0, 2 * spread)) - spread;
    if ($urandom_range(0, 15) == 0) begin
      // collinear: C on the line through A and B
      for (int k = 0; k < 3; k++) v[6 + k] = 2 * v[3 + k] - v[k];
    end
    return tri_of(v);
  endfunction

  // Drive one beat and hold start until it is taken.
  task automatic send_tri(in_t t);
    start <= 1'b1;
    in_i  <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    quad_pending = {quad_pending, plane_quadric(t)};
  endtask

  // Drop start for a random number of cycles, or keep the next beat back to back.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic check_field(string name, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %h got %h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Compare each result strobe with the oldest pending quadric.
  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || res_valid_o === 1'b1)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (quad_pending.size() == 0) begin
        $error("result beat with no pending triangle");
        n_fail++;
      end else begin
        out_t e;
        e = quad_pending.pop_front();
        check_field("q_aa", e.q_aa, res_o.q_aa);
        check_field("q_ab", e.q_ab, res_o.q_ab);
        check_field("q_ac", e.q_ac, res_o.q_ac);
        check_field("q_ad", e.q_ad, res_o.q_ad);
        check_field("q_bb", e.q_bb, res_o.q_bb);
        check_field("q_bc", e.q_bc, res_o.q_bc);
        check_field("q_bd", e.q_bd, res_o.q_bd);
        check_field("q_cc", e.q_cc, res_o.q_cc);
        check_field("q_cd", e.q_cd, res_o.q_cd);
        check_field("q_dd", e.q_dd, res_o.q_dd);
        check_field("degenerate", OUT_W'(e.degenerate), OUT_W'(res_o.degenerate));
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  typedef struct {
    int   v[9];
    logic typed_in;   // expected terms written below
    out_t want;
  } tri_row_t;

  tri_row_t tri_table[$];

  task automatic add_row(int v[9], logic typed_in, out_t want);
    tri_row_t r;
    r.v = v;
    r.typed_in = typed_in;
    r.want = want;
    tri_table = {tri_table, r};
  endtask

  initial begin
    out_t zero_deg;
    out_t unit_z;
    zero_deg = '0;
    zero_deg.degenerate = 1'b1;
    // Unit normal along +z through the origin: only c*c is one.
    unit_z = '0;
    unit_z.q_cc = 48'd1 << COEF_FRAC;

    add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, zero_deg);
    add_row('{100, 100, 100, 100, 100, 100, 100, 100, 100}, 1'b1, zero_deg);
    add_row('{0, 0, 0, 256, 256, 256, 512, 512, 512}, 1'b1, zero_deg);
    add_row('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
            1'b1, zero_deg);
    add_row('{0, 0, 0, 256, 0, 0, 0, 256, 0}, 1'b1, unit_z);
    add_row('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1'b1, unit_z);
    add_row('{0, 0, 0, 32767, 0, 0, 0, 32767, 0}, 1'b1, unit_z);
    add_row('{0, 0, 0, 0, 256, 0, 256, 0, 0}, 1'b0, '0);
    add_row('{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768}, 1'b0, '0);
    add_row('{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767}, 1'b0, '0);
    add_row('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767}, 1'b0, '0);
    add_row('{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767}, 1'b0, '0);
    add_row('{256, 512, 768, 300, 500, 700, -100, 900, 50}, 1'b0, '0);
    add_row('{0, 0, 0, 1, 1, 0, 0, 1, 1}, 1'b0, '0);
    add_row('{-1, -1, -1, 0, -1, -1, -1, 0, -1}, 1'b0, '0);
    add_row('{12345, -23456, 4321, -30000, 20000, -1, 7, 32767, -32768}, 1'b0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tri_table[i]) begin
      in_t t;
      t = tri_of(tri_table[i].v);
      if (tri_table[i].typed_in && plane_quadric(t) !== tri_table[i].want) begin
        $error("row %0d: predictor disagrees with typed-in terms", i);
        n_fail++;
      end
      send_tri(t);
      idle_gap();
    end

    // Hold off until the pipeline has drained once.
    start <= 1'b0;
    while (quad_pending.size() != 0) @(posedge clk_i);

    for (int i = 0; i < N_RANDOM; i++) begin
      send_tri(random_tri());
      idle_gap();
    end

    start <= 1'b0;
    while (quad_pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
